// ===== rtl/rrsdc_pkg.sv =====
// Types, condition masks, targets and step function for the right-branch trail checker.
`timescale 1ns / 1ps

package rrsdc_pkg;

    localparam int NUM_MSG   = 7;
    localparam int NUM_WORDS = 5;
    localparam int WORD_W    = 32;
    localparam int HIT_W     = 40;
    localparam int DEPTH_W   = 3;
    localparam int MSG_IDX_W = 3;
    localparam int IN_W      = NUM_WORDS * WORD_W;
    localparam int OUT_RAW_W = DEPTH_W + NUM_WORDS * HIT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int          DELTA_WORD  = 5;
    localparam logic [31:0] DELTA_VALUE = 32'h0000_8000;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_set_t;
    typedef logic [DEPTH_W-1:0]               depth_t;

    // Condition bits per chaining word: forced ones, forced zeros, and the
    // bits that differ between the two states.
    localparam word_set_t COND_ONE = {32'h0042_0080, 32'h0040_0000, 32'h0000_0080,
                                      32'h2000_0000, 32'h2000_0000};
    localparam word_set_t COND_ZERO = {32'h0000_0040, 32'h0000_0001, 32'h0000_0000,
                                       32'h0040_0000, 32'h0000_0080};
    localparam word_set_t COND_N = {32'h0000_0000, 32'h0000_0000, 32'h0040_0000,
                                    32'h0000_0000, 32'h0000_0000};
    localparam word_set_t COND_U = {32'h0000_0000, 32'h0000_0080, 32'h0000_0000,
                                    32'h0000_0000, 32'h0000_0000};

    localparam word_set_t TARGETS = {32'hf90f_8000, 32'h0000_03ff, 32'hff7f_4000,
                                     32'hf000_0000, 32'hfffe_0000};

    localparam logic [NUM_MSG-1:0][4:0] ROT_AMT = {5'd14, 5'd5, 5'd13, 5'd12,
                                                   5'd14, 5'd6, 5'd6};

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        return (v << s) | (v >> (6'd32 - {1'b0, s}));
    endfunction

    // One right-branch step with the ONZ function; the word set shifts down by one.
    function automatic word_set_t onz_step(input word_set_t x, input logic [31:0] m,
                                           input logic [4:0] r);
        logic [31:0] f;
        logic [31:0] t;
        logic [31:0] nw;
        word_set_t   y;
        f  = (x[4] | ~x[3]) ^ rotl32(x[2], 5'd10);
        t  = f + rotl32(x[0], 5'd10) + m;
        nw = rotl32(x[1], 5'd10) + rotl32(t, r);
        y  = {nw, x[4], x[3], x[2], x[1]};
        return y;
    endfunction

endpackage

// ===== rtl/ripemd_right_step_diff_checker.sv =====
// Top level: pipelined paired-state step runner, difference compare and hit counters.
// A request passes through the step stage registers, the depth register and the output register.
// Throughput: one request per cycle while the output is not stalled; each step stage advances both states.
// The output register lets the pipeline keep accepting while a result waits.
// Reset (rst_n low, asynchronous) clears all valid bits, message words and hit counters.
`timescale 1ns / 1ps

module ripemd_right_step_diff_checker
    import rrsdc_pkg::*;
#(
    parameter int STEPS       = 7,
    parameter int COUNT_WIDTH = 40
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [MSG_IDX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]    wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // seed_word_0 .. seed_word_4, 32 bits each
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // match_depth[2:0], hits_depth_1 .. hits_depth_5 (40 bits each), zero fill
    output logic [OUT_W-1:0]     m_axis_tdata
);

    // Stages 0..STEPS hold word sets; stage STEPS+1 holds the match depth.
    localparam int N_ST = STEPS + 2;

    logic [COUNT_WIDTH-1:0] cnt_max;
    assign cnt_max = '1;

    logic [WORD_W-1:0]     msg_reg [NUM_MSG];
    word_set_t             a_reg [STEPS+1];
    word_set_t             b_reg [STEPS+1];
    depth_t                depth_reg;
    depth_t                depth_next;
    depth_t                out_depth_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_WORDS];
    logic [N_ST-1:0]       valid_reg;
    logic [N_ST-1:0]       valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [N_ST:0]         can_take;
    logic [N_ST-1:0]       adv;
    logic                  in_accept;
    word_set_t             seed;
    word_set_t             cond_a;
    word_set_t             cond_b;
    logic [NUM_WORDS-1:0]  match;
    logic [HIT_W-1:0]      hits [NUM_WORDS];

    // Handshake chain: a stage moves on when the stage after it is free or moving.
    always_comb
    begin
        can_take[N_ST] = !out_valid_reg || m_axis_tready;
        for (int k = N_ST - 1; k >= 0; k--)
        begin
            adv[k]      = valid_reg[k] && can_take[k+1];
            can_take[k] = !valid_reg[k] || adv[k];
        end
    end

    assign s_axis_tready = can_take[0];
    assign in_accept     = s_axis_tvalid && can_take[0];

    always_comb
    begin
        valid_next[0] = in_accept ? 1'b1 : (adv[0] ? 1'b0 : valid_reg[0]);
        for (int k = 1; k < N_ST; k++)
        begin
            valid_next[k] = adv[k-1] ? 1'b1 : (adv[k] ? 1'b0 : valid_reg[k]);
        end
        out_valid_next = adv[N_ST-1] ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration: indexes past the last message word are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MSG; i++)
            begin
                msg_reg[i] <= '0;
            end
        end
        else if (wr_en && (32'(wr_index) < NUM_MSG))
        begin
            msg_reg[wr_index] <= wr_data;
        end
    end

    // Force the condition bits to build the two paired states.
    assign seed = s_axis_tdata;

    always_comb
    begin
        for (int j = 0; j < NUM_WORDS; j++)
        begin
            cond_a[j] = (seed[j] & ~(COND_ZERO[j] | COND_N[j])) | COND_ONE[j] | COND_U[j];
            cond_b[j] = (seed[j] & ~(COND_ZERO[j] | COND_U[j])) | COND_ONE[j] | COND_N[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_reg[0] <= cond_a;
            b_reg[0] <= cond_b;
        end
    end

    generate
        for (genvar s = 0; s < STEPS; s++)
        begin : g_step
            logic [WORD_W-1:0] m_b;
            assign m_b = msg_reg[s] + ((s == DELTA_WORD) ? DELTA_VALUE : 32'd0);

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    a_reg[s+1] <= onz_step(a_reg[s], msg_reg[s], ROT_AMT[s]);
                    b_reg[s+1] <= onz_step(b_reg[s], m_b, ROT_AMT[s]);
                end
            end
        end
    endgenerate

    // Compare the final modular differences in order against the targets.
    always_comb
    begin
        for (int j = 0; j < NUM_WORDS; j++)
        begin
            match[j] = ((b_reg[STEPS][j] - a_reg[STEPS][j]) == TARGETS[j]);
        end
        priority if (!match[0])
            depth_next = 3'd0;
        else if (!match[1])
            depth_next = 3'd1;
        else if (!match[2])
            depth_next = 3'd2;
        else if (!match[3])
            depth_next = 3'd3;
        else if (!match[4])
            depth_next = 3'd4;
        else
            depth_next = 3'd5;
    end

    always_ff @(posedge clk)
    begin
        if (adv[STEPS])
        begin
            depth_reg <= depth_next;
        end
        if (adv[N_ST-1])
        begin
            out_depth_reg <= depth_reg;
        end
    end

    // Counter j counts results whose depth reaches j+1; a full counter holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_WORDS; j++)
            begin
                cnt_reg[j] <= '0;
            end
        end
        else if (adv[N_ST-1])
        begin
            for (int j = 0; j < NUM_WORDS; j++)
            begin
                if ((depth_reg > DEPTH_W'(j)) && (cnt_reg[j] != cnt_max))
                begin
                    cnt_reg[j] <= cnt_reg[j] + 1'b1;
                end
            end
        end
    end

    generate
        for (genvar j = 0; j < NUM_WORDS; j++)
        begin : g_hits
            if (COUNT_WIDTH >= HIT_W)
            begin : g_trunc
                assign hits[j] = cnt_reg[j][HIT_W-1:0];
            end
            else
            begin : g_ext
                assign hits[j] = {{(HIT_W - COUNT_WIDTH){1'b0}}, cnt_reg[j]};
            end
        end
    endgenerate

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - OUT_RAW_W){1'b0}},
                            hits[4], hits[3], hits[2], hits[1], hits[0], out_depth_reg};

endmodule
